[sv/ctft_pkg.sv]
// shared types, constants and helpers for the checksummed text frame tokenizer
// no dependencies; every other file of the block but ctft_ifs imports this package
package ctft_pkg;

   // default and upper bound of the frame character limit
   localparam int MaxFrameCharsDefault = 4096;
   localparam int LimitWidth = 13;
   localparam logic [LimitWidth-1:0] LimitResetValue = 13'd1024;
   localparam logic [LimitWidth-1:0] CountMax = 13'h1FFF;

   // framing bytes
   localparam logic [7:0] ByteCr = 8'h0D;
   localparam logic [7:0] ByteLf = 8'h0A;
   localparam logic [7:0] ByteTab = 8'h09;
   localparam logic [7:0] SumSeed = 8'h17;

   // length of the checksum marker line including its tab
   localparam logic [7:0] MarkerLen = 8'd9;

   typedef enum logic [3:0] {
      KIND_FRAME_START = 4'd0,
      KIND_KEY_CHAR    = 4'd1,
      KIND_KEY_END     = 4'd2,
      KIND_VALUE_CHAR  = 4'd3,
      KIND_LINE_KEPT   = 4'd4,
      KIND_LINE_DROP   = 4'd5,
      KIND_MARKER      = 4'd6,
      KIND_FRAME_OK    = 4'd7,
      KIND_SUM_BAD     = 4'd8,
      KIND_OVERFLOW    = 4'd9
   } token_kind_type;

   // input item as it leaves the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_item_type;

   // result produced by the step logic
   typedef struct packed {
      logic           valid;
      token_kind_type kind;
      logic [7:0]     token_byte;
   } result_type;

   // characters of the marker line "Checksum" followed by a tab
   function automatic logic [7:0] marker_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h43;
         4'd1:    ch = 8'h68;
         4'd2:    ch = 8'h65;
         4'd3:    ch = 8'h63;
         4'd4:    ch = 8'h6B;
         4'd5:    ch = 8'h73;
         4'd6:    ch = 8'h75;
         4'd7:    ch = 8'h6D;
         4'd8:    ch = ByteTab;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[sv/ctft_ifs.sv]
// valid/ready channel interfaces for the tokenizer's byte input and token output
// depends on nothing
interface ctft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ctft_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [7:0] token_byte;

   modport source (output valid, output token_kind, output token_byte, input ready);
   modport sink (input valid, input token_kind, input token_byte, output ready);
endinterface

[sv/ctft_in_stage.sv]
// input register of the tokenizer: captures one byte item per cycle while it is empty or the next stage takes its item
// depends on ctft_pkg
module ctft_in_stage
   import ctft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   output logic        in_ready,
   input  logic        advance,
   output in_item_type item
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // the register frees up whenever the next stage takes its item
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

[sv/ctft_step.sv]
// frame state and per-byte tagging logic of the tokenizer, plus the limit register
// depends on ctft_pkg
module ctft_step
   import ctft_pkg::*;
#(
   parameter int MAX_FRAME_CHARS = MaxFrameCharsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [LimitWidth-1:0] csr_wr_data,
   input  in_item_type           item,
   input  logic                  fire,
   output result_type            result
);

   // effective limit is clamped so a saturated count always exceeds it
   localparam int CapInt = (MAX_FRAME_CHARS < 8190) ? MAX_FRAME_CHARS : 8190;
   localparam logic [LimitWidth-1:0] LimitCap = LimitWidth'(CapInt);
   localparam logic [LimitWidth-1:0] LimitReset =
      (LimitResetValue > LimitCap) ? LimitCap : LimitResetValue;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_SAWCR = 2'd1,
      MODE_FRAME = 2'd2
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            len_ff, len_in;
   logic                  tab_ff, tab_in;
   logic                  match_ff, match_in;
   logic                  key_ff, key_in;
   logic [LimitWidth-1:0] count_ff, count_in;
   logic [LimitWidth-1:0] limit_ff, limit_in;

   logic [7:0] b;
   logic [7:0] sum_add;
   logic       len_in_marker;
   logic       char_match;
   logic       match_next;

   assign b = item.rx_byte;
   assign sum_add = sum_ff + b;
   assign len_in_marker = (len_ff < MarkerLen);
   assign char_match = len_in_marker && (b == marker_char(len_ff[3:0]));
   assign match_next = match_ff && char_match;

   // clamp the limit on write
   always_comb begin
      limit_in = limit_ff;
      if (csr_wr_en) begin
         limit_in = (csr_wr_data > LimitCap) ? LimitCap : csr_wr_data;
      end
   end

   // one byte step
   always_comb begin
      mode_in = mode_ff;
      sum_in = sum_ff;
      len_in = len_ff;
      tab_in = tab_ff;
      match_in = match_ff;
      key_in = key_ff;
      count_in = count_ff;
      result.valid = 1'b0;
      result.kind = KIND_FRAME_START;
      result.token_byte = 8'h00;

      if (fire) begin
         if (mode_ff != MODE_FRAME) begin
            // hunt for CR then LF
            if (b == ByteCr) begin
               mode_in = MODE_SAWCR;
            end else if (b == ByteLf && mode_ff == MODE_SAWCR) begin
               mode_in = MODE_FRAME;
               sum_in = SumSeed;
               count_in = '0;
               len_in = '0;
               tab_in = 1'b0;
               match_in = 1'b1;
               key_in = 1'b0;
               result.valid = 1'b1;
               result.kind = KIND_FRAME_START;
            end else begin
               mode_in = MODE_IDLE;
            end
         end else if (match_ff && len_ff == MarkerLen) begin
            // checksum byte closes the frame
            result.valid = 1'b1;
            if (sum_add != 8'h00) begin
               result.kind = KIND_SUM_BAD;
            end else if (count_ff > limit_ff) begin
               result.kind = KIND_OVERFLOW;
            end else begin
               result.kind = KIND_FRAME_OK;
            end
            mode_in = MODE_IDLE;
            sum_in = 8'h00;
            count_in = '0;
            len_in = '0;
            tab_in = 1'b0;
            match_in = 1'b1;
            key_in = 1'b0;
         end else if (b == ByteLf) begin
            // end of line
            sum_in = sum_add;
            result.valid = 1'b1;
            result.kind = (tab_ff && key_ff) ? KIND_LINE_KEPT : KIND_LINE_DROP;
            len_in = '0;
            tab_in = 1'b0;
            match_in = 1'b1;
            key_in = 1'b0;
         end else if (b == ByteCr) begin
            sum_in = sum_add;
         end else begin
            // stored character
            sum_in = sum_add;
            match_in = match_next;
            if (len_ff != 8'hFF) begin
               len_in = len_ff + 8'd1;
            end
            if (count_ff != CountMax) begin
               count_in = count_ff + 1'b1;
            end
            result.valid = 1'b1;
            result.token_byte = b;
            if (!tab_ff && b == ByteTab) begin
               tab_in = 1'b1;
               key_in = (len_ff != 8'h00);
               result.kind = KIND_KEY_END;
            end else if (tab_ff) begin
               result.kind = KIND_VALUE_CHAR;
            end else begin
               result.kind = KIND_KEY_CHAR;
            end
            // marker line completed by its tab
            if (match_next && len_ff == MarkerLen - 8'd1) begin
               result.kind = KIND_MARKER;
               result.token_byte = 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         sum_ff <= 8'h00;
         len_ff <= 8'h00;
         tab_ff <= 1'b0;
         match_ff <= 1'b1;
         key_ff <= 1'b0;
         count_ff <= '0;
         limit_ff <= LimitReset;
      end else begin
         mode_ff <= mode_in;
         sum_ff <= sum_in;
         len_ff <= len_in;
         tab_ff <= tab_in;
         match_ff <= match_in;
         key_ff <= key_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

endmodule

[sv/ctft_out_stage.sv]
// result register of the tokenizer: holds one token item until it is taken
// depends on ctft_pkg
module ctft_out_stage
   import ctft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       can_take,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [3:0] out_kind,
   output logic [7:0] out_byte
);

   logic           valid_ff;
   logic           valid_in;
   token_kind_type kind_ff;
   logic [7:0]     byte_ff;

   // register is free when empty or being drained this cycle
   assign can_take = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_take) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (can_take && result.valid) begin
         kind_ff <= result.kind;
         byte_ff <= result.token_byte;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind = kind_ff;
   assign out_byte = byte_ff;

endmodule

[sv/checksummed_text_frame_tokenizer_unit.sv]
// Checksummed text frame tokenizer: takes one received byte per item and emits
// at most one token item for it (frame start, key/value characters, line end,
// checksum marker, frame verdict). Each byte passes an input register, the state
// update logic and a result register, and the unit sustains one byte per clock;
// the only throttle is backpressure on rsp, which stalls the result register and
// then req. The frame character limit is written through csr_wr_en/csr_wr_data;
// the user must write it only while idle, which the unit does not enforce. It is
// clamped to MAX_FRAME_CHARS and to 8190 on write.
// depends on ctft_pkg, ctft_ifs, ctft_in_stage, ctft_step, ctft_out_stage
module checksummed_text_frame_tokenizer_unit
   import ctft_pkg::*;
#(
   parameter int MAX_FRAME_CHARS = MaxFrameCharsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   ctft_req_if.sink              req,
   ctft_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [LimitWidth-1:0] csr_wr_data
);

   in_item_type item;
   result_type  result;
   logic        can_take;
   logic        fire;

   // a byte is processed when the result register can take its token
   assign fire = item.valid && can_take;

   ctft_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_byte  (req.rx_byte),
      .in_ready (req.ready),
      .advance  (can_take),
      .item     (item)
   );

   ctft_step #(
      .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item        (item),
      .fire        (fire),
      .result      (result)
   );

   ctft_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .can_take  (can_take),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_kind  (rsp.token_kind),
      .out_byte  (rsp.token_byte)
   );

endmodule

[sv/ctft_checker.sv]
// port-level checks on the tokenizer's token output, attached by bind
// depends on ctft_pkg and checksummed_text_frame_tokenizer_unit
module ctft_checker
   import ctft_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_token_kind,
   input logic [7:0] rsp_token_byte
);

   // no token item right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token item valid after reset");

   // only defined kinds leave the unit
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= KIND_OVERFLOW)
      else $error("token kind out of range");

   // non-character kinds carry a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_KEY_CHAR && rsp_token_kind != KIND_KEY_END
      && rsp_token_kind != KIND_VALUE_CHAR |-> rsp_token_byte == 8'h00)
      else $error("non-character token carries a byte");

   // the key end token is always the tab itself
   a_key_end_tab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_KEY_END |-> rsp_token_byte == ByteTab)
      else $error("key end token is not a tab");

   // a stalled token item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
      && $stable(rsp_token_byte))
      else $error("stalled token item changed");

endmodule

bind checksummed_text_frame_tokenizer_unit ctft_checker u_ctft_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_token_kind (rsp.token_kind),
   .rsp_token_byte (rsp.token_byte)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// testbench for checksummed_text_frame_tokenizer_unit: byte items in, token items out
// depends on ctft_pkg, the ctft_req_if/ctft_rsp_if interfaces and the unit itself
module tb_top;
   import ctft_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 80;
   localparam logic [71:0] CHECKSUM_TAG = {"Checksum", ByteTab};

   typedef enum logic [1:0] {
      SYNC_IDLE,
      SYNC_SAW_CR,
      SYNC_IN_FRAME
   } sync_state_type;

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     tbyte;
   } token_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [LimitWidth-1:0] csr_wr_data;

   ctft_req_if req_if ();
   ctft_rsp_if rsp_if ();

   checksummed_text_frame_tokenizer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tokenizer state as predicted
   sync_state_type  sync_state;
   logic [7:0]      frame_sum;
   logic [7:0]      line_len;
   logic            tab_seen;
   logic            tag_match;
   logic            key_nonempty;
   logic [12:0]     frame_chars;
   logic [12:0]     char_limit;

   token_type       expected_tokens[$];
   int              token_count = 0;
   int              mismatch_count = 0;

   // pacing controls
   bit              src_idles;
   bit              sink_idles;
   bit              hold_req;
   int              hold_left = 0;

   // bytes of the frame under construction
   logic [7:0]      frame_body[$];

   function automatic logic [7:0] tag_char(input int i);
      return CHECKSUM_TAG[8*(8-i) +: 8];
   endfunction

   function automatic void clear_line();
      line_len = 8'd0;
      tab_seen = 1'b0;
      tag_match = 1'b1;
      key_nonempty = 1'b0;
   endfunction

   // advance the predicted state by one byte; returns 1 when a token is due
   function automatic bit predict_token(input logic [7:0] b, output token_type tok);
      logic [12:0] cap;
      token_kind_type kind;
      tok.kind = KIND_FRAME_START;
      tok.tbyte = 8'h00;

      // hunting for CR LF
      if (sync_state != SYNC_IN_FRAME) begin
         if (b == ByteCr) begin
            sync_state = SYNC_SAW_CR;
         end else if (b == ByteLf && sync_state == SYNC_SAW_CR) begin
            sync_state = SYNC_IN_FRAME;
            frame_sum = SumSeed;
            frame_chars = '0;
            clear_line();
            return 1'b1;
         end else begin
            sync_state = SYNC_IDLE;
         end
         return 1'b0;
      end

      frame_sum = frame_sum + b;

      // byte after the marker line is the checksum, whatever it is
      if (tag_match && line_len == MarkerLen) begin
         cap = char_limit;
         if (cap > MaxFrameCharsDefault) cap = 13'(MaxFrameCharsDefault);
         if (cap > CountMax - 13'd1) cap = CountMax - 13'd1;
         if (frame_sum != 8'd0) tok.kind = KIND_SUM_BAD;
         else if (frame_chars > cap) tok.kind = KIND_OVERFLOW;
         else tok.kind = KIND_FRAME_OK;
         sync_state = SYNC_IDLE;
         frame_sum = 8'd0;
         frame_chars = '0;
         clear_line();
         return 1'b1;
      end

      if (b == ByteLf) begin
         tok.kind = (tab_seen && key_nonempty) ? KIND_LINE_KEPT : KIND_LINE_DROP;
         clear_line();
         return 1'b1;
      end

      if (b == ByteCr) return 1'b0;

      // stored character
      if (tag_match) tag_match = (line_len < MarkerLen) && (b == tag_char(int'(line_len)));
      if (!tab_seen && b == ByteTab) begin
         tab_seen = 1'b1;
         key_nonempty = (line_len != 8'd0);
         kind = KIND_KEY_END;
      end else if (tab_seen) begin
         kind = KIND_VALUE_CHAR;
      end else begin
         kind = KIND_KEY_CHAR;
      end
      if (line_len != 8'd255) line_len = line_len + 8'd1;
      if (frame_chars != CountMax) frame_chars = frame_chars + 13'd1;
      if (tag_match && line_len == MarkerLen) begin
         tok.kind = KIND_MARKER;
      end else begin
         tok.kind = kind;
         tok.tbyte = b;
      end
      return 1'b1;
   endfunction

   // prediction on accepted bytes, checking on accepted tokens, register tracking
   always @(posedge clock) begin : token_monitor
      token_type want;
      token_type tok;
      if (reset) begin
         sync_state = SYNC_IDLE;
         frame_sum = 8'd0;
         frame_chars = '0;
         char_limit = LimitResetValue;
         clear_line();
         expected_tokens.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected token, expected none, actual kind %0d byte %02h",
                        $time, rsp_if.token_kind, rsp_if.token_byte);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_if.token_kind !== want.kind) begin
                  $display("%0t: token_kind expected %0d actual %0d",
                           $time, want.kind, rsp_if.token_kind);
                  mismatch_count++;
               end
               if (rsp_if.token_byte !== want.tbyte) begin
                  $display("%0t: token_byte expected %02h actual %02h",
                           $time, want.tbyte, rsp_if.token_byte);
                  mismatch_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (predict_token(req_if.rx_byte, tok)) begin
               expected_tokens.push_back(tok);
               token_count++;
            end
         end
         if (csr_wr_en) char_limit = csr_wr_data;
      end
   end

   // token side pacing: random stalls plus a long hold on request
   always @(posedge clock) begin : rsp_pacing
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !(sink_idles && $urandom_range(99) < 33);
      end
   end

   // run ends here if traffic never drains
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // offer one byte and wait for it to be taken
   task automatic send_byte(input logic [7:0] b);
      while (src_idles && $urandom_range(99) < 33) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_body();
      foreach (frame_body[i]) send_byte(frame_body[i]);
   endtask

   // CR LF, body, marker line, then the checksum byte shifted by sum_offset
   task automatic send_frame(input logic [7:0] sum_offset);
      logic [7:0] total;
      total = SumSeed;
      foreach (frame_body[i]) total = total + frame_body[i];
      for (int i = 0; i < 9; i++) total = total + tag_char(i);
      send_byte(ByteCr);
      send_byte(ByteLf);
      send_body();
      for (int i = 0; i < 9; i++) send_byte(tag_char(i));
      send_byte(8'h00 - total + sum_offset);
   endtask

   // wait until all due tokens are out and the pipeline has gone quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] rand_value_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == ByteLf) b = 8'hFF;
      return b;
   endfunction

   // body of one line: non-empty key, tab, n value bytes, LF
   function automatic void make_value_line(input int n);
      frame_body.delete();
      frame_body.push_back(8'h4B);
      frame_body.push_back(ByteTab);
      for (int i = 0; i < n; i++) frame_body.push_back(rand_value_byte());
      frame_body.push_back(ByteLf);
   endfunction

   // append one random line to the frame body
   function automatic void add_line();
      int shape;
      int n;
      shape = $urandom_range(99);
      if (shape < 8) begin
         // partial or near-miss marker text
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) frame_body.push_back(tag_char(i));
         frame_body.push_back(rand_value_byte());
      end else begin
         n = (shape < 18) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) frame_body.push_back(8'($urandom_range(8'h21, 8'h7E)));
         if (shape < 90) frame_body.push_back(ByteTab);
         n = $urandom_range(0, 10);
         for (int i = 0; i < n; i++) frame_body.push_back(rand_value_byte());
      end
      frame_body.push_back(ByteLf);
   endfunction

   // mostly well-formed frames, some noise and frames left open
   task automatic random_traffic(input int tokens);
      int stop;
      int pick;
      int b;
      stop = token_count + tokens;
      while (token_count < stop) begin
         pick = $urandom_range(99);
         frame_body.delete();
         repeat ($urandom_range(1, 5)) add_line();
         if (pick < 75) begin
            send_frame((pick < 64) ? 8'h00 : 8'($urandom_range(1, 255)));
         end else if (pick < 87) begin
            repeat ($urandom_range(1, 6)) begin
               b = $urandom_range(99);
               if (b < 30) send_byte(ByteCr);
               else if (b < 50) send_byte(ByteLf);
               else send_byte(8'($urandom_range(255)));
            end
         end else begin
            send_byte(ByteCr);
            send_byte(ByteLf);
            send_body();
         end
      end
   endtask

   // noise, CR CR LF hunt, empty key, later tabs, in-frame CR, byte extremes
   task automatic test_directed();
      frame_body = {8'h61, ByteCr, 8'h62, ByteLf, ByteCr};
      send_body();
      frame_body = {ByteTab, 8'h78, ByteLf,
                    8'h4B, ByteTab, ByteTab, 8'h00, 8'hFF, ByteCr, ByteLf,
                    8'h6E, ByteLf};
      send_frame(8'h00);
   endtask

   // checksum byte equal to LF with a good sum, and CR with a bad one
   task automatic test_checksum_byte();
      frame_body = {8'h99, ByteLf};
      send_frame(8'h00);
      frame_body.delete();
      send_frame(8'h60);
   endtask

   // overflow boundary, limit zero, top limit and clamp, with a long saturating line
   task automatic test_limits();
      write_limit(13'd12);
      make_value_line(1);
      send_frame(8'h00);
      make_value_line(2);
      send_frame(8'h00);
      send_frame(8'h01);
      write_limit(13'd1);
      frame_body.delete();
      send_frame(8'h00);
      write_limit(13'd0);
      send_frame(8'h00);
      write_limit(13'd4096);
      make_value_line(300);
      send_frame(8'h00);
      write_limit(13'd8191);
      make_value_line(2);
      send_frame(8'h00);
      write_limit(LimitResetValue);
   endtask

   // hold the token side while bytes keep coming so the unit backs up
   task automatic test_backpressure();
      settle();
      src_idles = 1'b0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      make_value_line(60);
      send_frame(8'h00);
      src_idles = 1'b1;
   endtask

   // a stretch with no idling on either side
   task automatic test_streaming();
      settle();
      src_idles = 1'b0;
      sink_idles <= 1'b0;
      random_traffic(150);
      settle();
      src_idles = 1'b1;
      sink_idles <= 1'b1;
   endtask

   task automatic test_random();
      logic [LimitWidth-1:0] limits[8];
      limits = '{13'd30, 13'd0, 13'd8191, 13'd4096, 13'd1, 13'd60, 13'd1024, 13'd0};
      limits[7] = 13'($urandom_range(9, 200));
      foreach (limits[i]) begin
         write_limit(limits[i]);
         random_traffic(130);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      src_idles = 1'b1;
      sink_idles = 1'b1;
      hold_req = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_checksum_byte();
      test_limits();
      test_backpressure();
      test_streaming();
      test_random();
      settle();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
sv/ctft_pkg.sv
sv/ctft_ifs.sv
sv/ctft_in_stage.sv
sv/ctft_step.sv
sv/ctft_out_stage.sv
sv/checksummed_text_frame_tokenizer_unit.sv
sv/ctft_checker.sv
test/tb_top.sv
